// File: rtl/core/pspw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pspw_pkg
// Shared types, constants and helpers for the per-second pulse window.
// -----------------------------------------------------------------------------
package pspw_pkg;

   // Ring depth must stay a power of two: slots are the low bits of a time.
   localparam int RING_DEPTH = 64;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   localparam int OP_W    = 2;
   localparam int TIME_W  = 32;
   localparam int PULSE_W = 16;
   localparam int WIN_W   = 7;
   localparam int SUM_W   = 22;
   localparam int USED_W  = 7;

   localparam int SUM_MAX  = 4194303;
   localparam int USED_MAX = 127;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 2'd0,
      OP_ADVANCE = 2'd1,
      OP_ADD     = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADV_STEP,
      ST_ADD_WR,
      ST_QRY_RUN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic do_clear;
      logic prime;
      logic wipe;
      logic step_head;
      logic add_read;
      logic add_write;
      logic qry_start;
      logic qry_read;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   primed;
      logic   not_ahead;
      logic   gap_full;
      logic   pulses_zero;
      logic   head_at_now;
      logic   qry_done;
      logic   rsp_free;
   } status_type;

   function automatic cnt_type clamp_depth(input logic [WIN_W-1:0] v);
      if (int'(v) > RING_DEPTH) begin
         return cnt_type'(RING_DEPTH);
      end
      return cnt_type'(v);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/pspw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pspw_if
// Request and response channels of the pulse window, valid/ready handshake.
// -----------------------------------------------------------------------------
interface pspw_req_if;
   logic                                valid;
   logic                                ready;
   logic [pspw_pkg::OP_W-1:0]           operation;
   logic [pspw_pkg::TIME_W-1:0]         now_seconds;
   logic [pspw_pkg::PULSE_W-1:0]        pulse_count;
   logic [pspw_pkg::WIN_W-1:0]          offset_back;
   logic [pspw_pkg::WIN_W-1:0]          span_length;

   modport source (
      output valid, operation, now_seconds, pulse_count, offset_back, span_length,
      input  ready
   );
   modport sink (
      input  valid, operation, now_seconds, pulse_count, offset_back, span_length,
      output ready
   );
endinterface

interface pspw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pspw_pkg::SUM_W-1:0]          window_sum;
   logic [pspw_pkg::USED_W-1:0]         used_count;

   modport source (
      output valid, window_sum, used_count,
      input  ready
   );
   modport sink (
      input  valid, window_sum, used_count,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/core/per_second_pulse_window.sv
// Sequence: clear, prime, full-ring wipe and stale time finish in the decode state; add reads
// the head bucket, then writes it; an advance by g seconds (g below the ring size) steps the
// head second by second; a query walks u buckets, loads the response register, then frees the
// request side. Throughput: one word at a time, set by the query walk (one bucket read
// per cycle) and head stepping (one second per cycle); a query also holds while the previous
// response word waits. Reset: synchronous; every bucket reads zero after reset.
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// per_second_pulse_window
// Sliding window of per-second pulse buckets with clear, advance, add and sum.
// -----------------------------------------------------------------------------
module per_second_pulse_window (
   input  wire logic  clock,
   input  wire logic  reset,
   pspw_req_if.sink   req_if,
   pspw_rsp_if.source rsp_if
);

   pspw_pkg::cmd_type    cmd;
   pspw_pkg::status_type status;

   // Sequencer: takes a word only when idle, then drives the datapath one
   // step per cycle, waiting while a finished sum cannot yet be loaded, until the word is done.
   pspw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: holds the captured word, the ring state and the bucket memory.
   // The response register sits here too, so a new word can be taken while a
   // finished sum still waits on the response side.
   pspw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_if.operation),
      .req_now_seconds (req_if.now_seconds),
      .req_pulse_count (req_if.pulse_count),
      .req_offset_back (req_if.offset_back),
      .req_span_length (req_if.span_length),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_window_sum  (rsp_if.window_sum),
      .rsp_used_count  (rsp_if.used_count),
      .status          (status)
   );

`ifndef SYNTHESIS
   // A response word appears only after the sequencer loads it.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.rsp_load))
      else $error("response valid rose without a load");

   // While ready, no multi-cycle work may be in flight.
   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> (!cmd.qry_read && !cmd.add_write && !cmd.step_head))
      else $error("datapath busy while request side is ready");

   // The walker never reads past the bucket count it settled on.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.qry_read |-> !status.qry_done)
      else $error("query read issued after walk completed");

   // An accepted word is decoded before the next one is taken.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken back to back");
`endif

endmodule
`default_nettype wire

// File: rtl/core/pspw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pspw_ctrl
// Sequencer: decodes a captured word and steps the datapath through it.
// -----------------------------------------------------------------------------
module pspw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pspw_pkg::status_type status,
   output pspw_pkg::cmd_type         cmd
);

   pspw_pkg::state_type state_ff;
   pspw_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pspw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pspw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pspw_pkg::ST_DECODE;
            end
         end
         pspw_pkg::ST_DECODE: begin
            state_in = pspw_pkg::ST_IDLE;
            case (status.op)
               pspw_pkg::OP_CLEAR: begin
                  cmd.do_clear = 1'b1;
               end
               pspw_pkg::OP_ADVANCE: begin
                  if (!status.primed) begin
                     cmd.prime = 1'b1;
                  end else if (status.not_ahead) begin
                     state_in = pspw_pkg::ST_IDLE;
                  end else if (status.gap_full) begin
                     cmd.wipe = 1'b1;
                  end else begin
                     state_in = pspw_pkg::ST_ADV_STEP;
                  end
               end
               pspw_pkg::OP_ADD: begin
                  if (status.primed && !status.pulses_zero) begin
                     cmd.add_read = 1'b1;
                     state_in     = pspw_pkg::ST_ADD_WR;
                  end
               end
               pspw_pkg::OP_QUERY: begin
                  cmd.qry_start = 1'b1;
                  state_in      = pspw_pkg::ST_QRY_RUN;
               end
               default: begin
                  state_in = pspw_pkg::ST_IDLE;
               end
            endcase
         end
         pspw_pkg::ST_ADV_STEP: begin
            if (status.head_at_now) begin
               state_in = pspw_pkg::ST_IDLE;
            end else begin
               cmd.step_head = 1'b1;
            end
         end
         pspw_pkg::ST_ADD_WR: begin
            cmd.add_write = 1'b1;
            state_in      = pspw_pkg::ST_IDLE;
         end
         pspw_pkg::ST_QRY_RUN: begin
            if (status.qry_done) begin
               state_in = pspw_pkg::ST_RESP;
            end else begin
               cmd.qry_read = 1'b1;
            end
         end
         pspw_pkg::ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = pspw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pspw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/pspw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pspw_datapath
// Bucket memory, head/fill registers, query walker and response register.
// -----------------------------------------------------------------------------
module pspw_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pspw_pkg::cmd_type                   cmd,
   input  wire logic [pspw_pkg::OP_W-1:0]           req_operation,
   input  wire logic [pspw_pkg::TIME_W-1:0]         req_now_seconds,
   input  wire logic [pspw_pkg::PULSE_W-1:0]        req_pulse_count,
   input  wire logic [pspw_pkg::WIN_W-1:0]          req_offset_back,
   input  wire logic [pspw_pkg::WIN_W-1:0]          req_span_length,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [pspw_pkg::SUM_W-1:0]               rsp_window_sum,
   output logic [pspw_pkg::USED_W-1:0]              rsp_used_count,
   output pspw_pkg::status_type                     status
);

   // captured word
   pspw_pkg::op_type                  op_ff;
   logic [pspw_pkg::TIME_W-1:0]       now_ff;
   logic [pspw_pkg::PULSE_W-1:0]      pulses_ff;
   pspw_pkg::cnt_type                 offset_ff;
   pspw_pkg::cnt_type                 span_ff;

   // ring state
   logic                              primed_ff;
   logic [pspw_pkg::TIME_W-1:0]       head_ff;
   pspw_pkg::cnt_type                 filled_ff;
   logic [pspw_pkg::RING_DEPTH-1:0]   bvalid_ff;
   logic [pspw_pkg::PULSE_W-1:0]      bucket_mem [pspw_pkg::RING_DEPTH];
   logic [pspw_pkg::PULSE_W-1:0]      rd_data_ff;
   logic                              rd_bvalid_ff;
   logic                              rd_qry_ff;

   // query walker
   pspw_pkg::cnt_type                 k_ff;
   pspw_pkg::cnt_type                 used_ff;
   pspw_pkg::idx_type                 ptr_ff;
   logic [pspw_pkg::SUM_W-1:0]        acc_ff;

   // response register
   logic                              rsp_valid_ff;
   logic [pspw_pkg::SUM_W-1:0]        rsp_sum_ff;
   logic [pspw_pkg::USED_W-1:0]       rsp_used_ff;

   pspw_pkg::idx_type                 head_slot;
   pspw_pkg::idx_type                 next_slot;
   pspw_pkg::idx_type                 now_slot;
   pspw_pkg::idx_type                 rd_addr;
   logic [pspw_pkg::TIME_W-1:0]       gap;
   logic                              qry_empty;
   pspw_pkg::cnt_type                 avail;
   pspw_pkg::cnt_type                 used_calc;
   logic [pspw_pkg::PULSE_W-1:0]      bucket;
   logic [pspw_pkg::PULSE_W:0]        add_sum;
   logic [pspw_pkg::PULSE_W-1:0]      wr_data;
   logic [pspw_pkg::SUM_W:0]          acc_sum;
   logic [pspw_pkg::SUM_W-1:0]        acc_in;
   logic [pspw_pkg::USED_W-1:0]       used_out;

   assign head_slot = head_ff[pspw_pkg::IDX_W-1:0];
   assign next_slot = head_slot + pspw_pkg::idx_type'(1);
   assign now_slot  = now_ff[pspw_pkg::IDX_W-1:0];
   assign gap       = now_ff - head_ff;

   assign qry_empty = !primed_ff || (offset_ff >= filled_ff);
   assign avail     = filled_ff - offset_ff;
   assign used_calc = qry_empty ? '0 : ((span_ff < avail) ? span_ff : avail);

   assign rd_addr   = cmd.add_read ? head_slot : ptr_ff;
   assign bucket    = rd_bvalid_ff ? rd_data_ff : '0;

   assign add_sum   = {1'b0, bucket} + {1'b0, pulses_ff};
   assign wr_data   = add_sum[pspw_pkg::PULSE_W] ? '1 : add_sum[pspw_pkg::PULSE_W-1:0];

   assign acc_sum   = {1'b0, acc_ff} + (pspw_pkg::SUM_W + 1)'(bucket);
   assign acc_in    = (acc_sum > (pspw_pkg::SUM_W + 1)'(pspw_pkg::SUM_MAX))
                    ? pspw_pkg::SUM_W'(pspw_pkg::SUM_MAX) : acc_sum[pspw_pkg::SUM_W-1:0];

   assign used_out  = (int'(used_ff) > pspw_pkg::USED_MAX)
                    ? pspw_pkg::USED_W'(pspw_pkg::USED_MAX) : pspw_pkg::USED_W'(used_ff);

   always_comb begin
      status.op          = op_ff;
      status.primed      = primed_ff;
      status.not_ahead   = now_ff <= head_ff;
      status.gap_full    = gap >= pspw_pkg::TIME_W'(pspw_pkg::RING_DEPTH);
      status.pulses_zero = pulses_ff == '0;
      status.head_at_now = head_ff == now_ff;
      status.qry_done    = k_ff == used_ff;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= pspw_pkg::op_type'(req_operation);
         now_ff    <= req_now_seconds;
         pulses_ff <= req_pulse_count;
         offset_ff <= pspw_pkg::clamp_depth(req_offset_back);
         span_ff   <= pspw_pkg::clamp_depth(req_span_length);
      end
   end

   // head, fill count and primed flag
   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear) begin
         primed_ff <= 1'b0;
         head_ff   <= '0;
         filled_ff <= '0;
      end else if (cmd.prime || cmd.wipe) begin
         primed_ff <= 1'b1;
         head_ff   <= now_ff;
         filled_ff <= pspw_pkg::cnt_type'(1);
      end else if (cmd.step_head) begin
         head_ff <= head_ff + 1'b1;
         if (filled_ff < pspw_pkg::cnt_type'(pspw_pkg::RING_DEPTH)) begin
            filled_ff <= filled_ff + 1'b1;
         end
      end
   end

   // per-bucket valid flags: a bucket not written since its last wipe reads zero
   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear || cmd.wipe) begin
         bvalid_ff <= '0;
      end else if (cmd.prime) begin
         bvalid_ff[now_slot] <= 1'b0;
      end else if (cmd.step_head) begin
         bvalid_ff[next_slot] <= 1'b0;
      end else if (cmd.add_write) begin
         bvalid_ff[head_slot] <= 1'b1;
      end
   end

   // bucket memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         bucket_mem[head_slot] <= wr_data;
      end
      rd_data_ff   <= bucket_mem[rd_addr];
      rd_bvalid_ff <= bvalid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_qry_ff <= 1'b0;
      end else begin
         rd_qry_ff <= cmd.qry_read;
      end
   end

   // query walker: one bucket read a cycle, each read accumulated in the cycle after it
   always_ff @(posedge clock) begin
      if (cmd.qry_start) begin
         k_ff    <= '0;
         used_ff <= used_calc;
         ptr_ff  <= head_slot - offset_ff[pspw_pkg::IDX_W-1:0];
         acc_ff  <= '0;
      end else begin
         if (cmd.qry_read) begin
            k_ff   <= k_ff + 1'b1;
            ptr_ff <= ptr_ff - 1'b1;
         end
         if (rd_qry_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_sum_ff  <= acc_ff;
         rsp_used_ff <= used_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_sum = rsp_sum_ff;
   assign rsp_used_count = rsp_used_ff;

endmodule
`default_nettype wire

// File: bench/per_second_pulse_window_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// per_second_pulse_window_test
// Self-checking bench for the per-second pulse window. A short directed run
// covers the unprimed ring, saturation, every kind of advance, window limits
// and clear. A long random run follows, with random idling on both channels.
// Every query word is predicted from a local model of the bucket ring and
// compared field by field with the response word.
// -----------------------------------------------------------------------------
module per_second_pulse_window_test;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned RANDOM_WORDS = 1330;

   typedef struct packed {
      pspw_pkg::op_type                  op;
      logic [pspw_pkg::TIME_W-1:0]       now;
      logic [pspw_pkg::PULSE_W-1:0]      pulses;
      logic [pspw_pkg::WIN_W-1:0]        offset;
      logic [pspw_pkg::WIN_W-1:0]        span;
   } pulse_word_type;

   typedef struct packed {
      logic [pspw_pkg::SUM_W-1:0]        sum;
      logic [pspw_pkg::USED_W-1:0]       used;
   } window_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   bit          calm = 1'b0;   // set: no idling on either channel

   // Window sums still owed by the block, oldest first.
   window_result_type pending_sums[$];

   // Local copy of the ring state.
   bit                             ring_primed;
   logic [pspw_pkg::TIME_W-1:0]    ring_head;
   int unsigned                    ring_filled;
   logic [pspw_pkg::PULSE_W-1:0]   ring_bucket[pspw_pkg::RING_DEPTH];

   pspw_req_if req_bus();
   pspw_rsp_if rsp_bus();

   per_second_pulse_window dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the traffic never drains.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- model
   function automatic void clear_ring();
      ring_primed = 1'b0;
      ring_head   = '0;
      ring_filled = 0;
      for (int i = 0; i < pspw_pkg::RING_DEPTH; i++) begin
         ring_bucket[i] = '0;
      end
   endfunction

   function automatic void advance_ring(input logic [pspw_pkg::TIME_W-1:0] now);
      if (!ring_primed) begin
         // First advance: prime, the head bucket starts empty.
         ring_primed = 1'b1;
         ring_head   = now;
         ring_filled = 1;
         ring_bucket[now[pspw_pkg::IDX_W-1:0]] = '0;
      end else if (now > ring_head) begin
         if (now - ring_head >= pspw_pkg::RING_DEPTH) begin
            // Gap covers the whole ring: wipe everything.
            for (int i = 0; i < pspw_pkg::RING_DEPTH; i++) begin
               ring_bucket[i] = '0;
            end
            ring_head   = now;
            ring_filled = 1;
         end else begin
            // Step second by second, zeroing each entered bucket.
            while (ring_head < now) begin
               ring_head++;
               ring_bucket[ring_head[pspw_pkg::IDX_W-1:0]] = '0;
               if (ring_filled < pspw_pkg::RING_DEPTH) ring_filled++;
            end
         end
      end
   endfunction

   function automatic void add_to_head(input logic [pspw_pkg::PULSE_W-1:0] pulses);
      int unsigned total;
      if (ring_primed && pulses != 0) begin
         total = ring_bucket[ring_head[pspw_pkg::IDX_W-1:0]] + pulses;
         ring_bucket[ring_head[pspw_pkg::IDX_W-1:0]] =
            (total > 65535) ? 16'hFFFF : total[15:0];
      end
   endfunction

   function automatic window_result_type sum_window(
         input logic [pspw_pkg::WIN_W-1:0] offset,
         input logic [pspw_pkg::WIN_W-1:0] span);
      int unsigned                    off;
      int unsigned                    len;
      int unsigned                    used;
      int unsigned                    total;
      logic [pspw_pkg::TIME_W-1:0]    t;
      window_result_type              res;
      off   = (offset > pspw_pkg::RING_DEPTH) ? pspw_pkg::RING_DEPTH : offset;
      len   = (span > pspw_pkg::RING_DEPTH) ? pspw_pkg::RING_DEPTH : span;
      used  = 0;
      total = 0;
      if (ring_primed && off < ring_filled) begin
         used = (len < ring_filled - off) ? len : ring_filled - off;
         for (int unsigned k = 0; k < used; k++) begin
            t = ring_head - off - k;
            total += ring_bucket[t[pspw_pkg::IDX_W-1:0]];
         end
      end
      if (total > pspw_pkg::SUM_MAX) total = pspw_pkg::SUM_MAX;
      if (used > pspw_pkg::USED_MAX) used = pspw_pkg::USED_MAX;
      res.sum  = total[pspw_pkg::SUM_W-1:0];
      res.used = used[pspw_pkg::USED_W-1:0];
      return res;
   endfunction

   // Update the model with one accepted word; queue the sum it owes.
   function automatic void apply_word(input pulse_word_type w);
      case (w.op)
         pspw_pkg::OP_CLEAR:   clear_ring();
         pspw_pkg::OP_ADVANCE: advance_ring(w.now);
         pspw_pkg::OP_ADD:     add_to_head(w.pulses);
         pspw_pkg::OP_QUERY:   pending_sums.push_back(sum_window(w.offset, w.span));
         default:              ;
      endcase
   endfunction

   // ---------------------------------------------------------------- drive
   // Mostly short gaps, a few long ones, none while calm.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic pulse_word_type make_word(
         input pspw_pkg::op_type               op,
         input logic [pspw_pkg::TIME_W-1:0]    now,
         input logic [pspw_pkg::PULSE_W-1:0]   pulses,
         input logic [pspw_pkg::WIN_W-1:0]     offset,
         input logic [pspw_pkg::WIN_W-1:0]     span);
      pulse_word_type w;
      w.op     = op;
      w.now    = now;
      w.pulses = pulses;
      w.offset = offset;
      w.span   = span;
      return w;
   endfunction

   // Hold the word until accepted, then advance the model.
   // Valid stays high after acceptance; the next call drops or reuses it.
   task automatic send_word(input pulse_word_type w);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.operation   = w.op;
      req_bus.now_seconds = w.now;
      req_bus.pulse_count = w.pulses;
      req_bus.offset_back = w.offset;
      req_bus.span_length = w.span;
      req_bus.valid       = 1'b1;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      apply_word(w);
   endtask

   // ---------------------------------------------------------------- check
   initial begin
      window_result_type want;
      int unsigned       stall;
      stall         = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_sums.size() == 0) begin
               $error("unexpected result word: window_sum %0d used_count %0d",
                      rsp_bus.window_sum, rsp_bus.used_count);
               error_count++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp_bus.window_sum !== want.sum) begin
                  $error("window_sum: expected %0d, actual %0d", want.sum,
                         rsp_bus.window_sum);
                  error_count++;
               end
               if (rsp_bus.used_count !== want.used) begin
                  $error("used_count: expected %0d, actual %0d", want.used,
                         rsp_bus.used_count);
                  error_count++;
               end
            end
         end
         @(negedge clock);
         // Hold ready low through a stall, otherwise raise it and maybe start one.
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // Adds and queries against a ring that has never been primed.
   task automatic test_unprimed_ring();
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd0, 7'd64));
      send_word(make_word(pspw_pkg::OP_ADD, '0, 16'hFFFF, '0, '0));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd0, 7'd1));
   endtask

   // Prime near the top of the time range, then saturate the head bucket.
   task automatic test_add_saturation();
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'hFFFF_FF00, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADD, '0, 16'd0, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADD, '0, 16'hFFFF, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADD, '0, 16'd1, '0, '0));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd0, 7'd64));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd1, 7'd1));
   endtask

   // Time not ahead, a short gap and a full-ring gap.
   task automatic test_advance_cases();
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'hFFFF_FF00, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'h0000_0005, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'hFFFF_FF01, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADD, '0, 16'd12345, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'hFFFF_FF06, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADD, '0, 16'd7, '0, '0));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd0, 7'd64));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd2, 7'd5));
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'hFFFF_FF46, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd0, 7'd64));
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'hFFFF_FFFF, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_ADD, '0, 16'd100, '0, '0));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd64, 7'd64));
   endtask

   // Clear drops the priming; time zero primes again.
   task automatic test_clear();
      send_word(make_word(pspw_pkg::OP_CLEAR, '0, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd0, 7'd0));
      send_word(make_word(pspw_pkg::OP_ADVANCE, 32'h0, '0, '0, '0));
      send_word(make_word(pspw_pkg::OP_QUERY, '0, '0, 7'd0, 7'd0));
   endtask

   // Mostly live seconds with adds and queries; some clears, stale times and noise.
   task automatic test_random_traffic(input int unsigned n_words);
      pulse_word_type w;
      int unsigned    r;
      int unsigned    d;
      for (int unsigned i = 0; i < n_words; i++) begin
         calm = ((i % 200) >= 150);
         // Random filler in the fields the operation does not use.
         w.now    = $urandom;
         w.pulses = pspw_pkg::PULSE_W'($urandom);
         w.offset = pspw_pkg::WIN_W'($urandom_range(64, 0));
         w.span   = pspw_pkg::WIN_W'($urandom_range(64, 0));
         r = $urandom_range(99, 0);
         if (!ring_primed && r < 85) begin
            w.op = pspw_pkg::OP_ADVANCE;
            if (w.now[31:28] == 4'hF && $urandom_range(3, 0) != 0) w.now[31] = 1'b0;
         end else if (r < 1) begin
            w.op = pspw_pkg::OP_CLEAR;
         end else if (r < 38) begin
            w.op = pspw_pkg::OP_ADVANCE;
            d = $urandom_range(99, 0);
            if (d < 55)      w.now = ring_head + 1;
            else if (d < 75) w.now = ring_head + $urandom_range(8, 2);
            else if (d < 89) w.now = ring_head + $urandom_range(63, 9);
            else if (d < 92) w.now = ring_head + $urandom_range(300, 64);
            else if (d < 97) w.now = ring_head - $urandom_range(5, 0);
            // else keep the random time
         end else if (r < 70) begin
            w.op = pspw_pkg::OP_ADD;
            d = $urandom_range(99, 0);
            if (d < 10)      w.pulses = '0;
            else if (d < 25) w.pulses = 16'hFFFF;
            else if (d < 50) w.pulses = pspw_pkg::PULSE_W'($urandom_range(255, 1));
         end else begin
            w.op = pspw_pkg::OP_QUERY;
            d = $urandom_range(99, 0);
            if (d < 60)      w.offset = pspw_pkg::WIN_W'($urandom_range(8, 0));
            else if (d < 70) w.offset = 7'd64;
            d = $urandom_range(99, 0);
            if (d < 20)      w.span = 7'd64;
            else if (d < 30) w.span = 7'd0;
            else             w.span = pspw_pkg::WIN_W'($urandom_range(64, 1));
         end
         send_word(w);
      end
      calm = 1'b0;
   endtask

   // ---------------------------------------------------------------- main
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.operation   = pspw_pkg::OP_CLEAR;
      req_bus.now_seconds = '0;
      req_bus.pulse_count = '0;
      req_bus.offset_back = '0;
      req_bus.span_length = '0;
      clear_ring();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_unprimed_ring();
      test_add_saturation();
      test_advance_cases();
      test_clear();
      test_random_traffic(RANDOM_WORDS);

      // Drop valid, drain the owed sums, then let the last advance settle.
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/pspw_pkg.sv
rtl/core/pspw_if.sv
rtl/core/pspw_ctrl.sv
rtl/core/pspw_datapath.sv
rtl/core/per_second_pulse_window.sv
bench/per_second_pulse_window_test.sv
